[sv/frame_alignment_min_cost_dp_top_assert.svh]
// Assertion macros for the frame alignment block.
`ifndef FRAME_ALIGNMENT_MIN_COST_DP_TOP_ASSERT_SVH
`define FRAME_ALIGNMENT_MIN_COST_DP_TOP_ASSERT_SVH

// Same-cycle implication, clocked on clk, off during reset.
`define FAMC_ASSERT_IMP(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("same-cycle check failed");

// Next-cycle implication, clocked on clk, off during reset.
`define FAMC_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("next-cycle check failed");

`endif

[sv/famcdp_pkg.sv]
// Shared types, constants and helpers for the frame alignment block.
`timescale 1ns / 1ps
package famcdp_pkg;
	localparam int MAX_FRAMES  = 1024;
	localparam int IDX_W       = $clog2(MAX_FRAMES);
	localparam int CNT_W       = $clog2(MAX_FRAMES + 1);
	localparam int LEN_REG_W   = 11;
	localparam int SCORE_W     = 16;
	localparam int COST_W      = SCORE_W + 1;
	localparam int SUM_W       = 27;
	localparam int PLEN_W      = 12;
	localparam int PROD_W      = CNT_W + 1 + COST_W;
	localparam int ONE_Q14     = 16384;
	localparam int QUEUE_DEPTH = 4;
	localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
	localparam int CFG_ADDR_W  = 2;
	localparam int CFG_DATA_W  = 16;

	typedef enum logic [CFG_ADDR_W-1:0] {
		REG_FIRST_LEN  = 2'd0,
		REG_SECOND_LEN = 2'd1,
		REG_DEL_SCORE  = 2'd2,
		REG_INS_SCORE  = 2'd3
	} cfg_reg_t;

	// one classified cell on its way from front to back
	typedef struct packed {
		logic signed [SCORE_W-1:0] score;
		logic [IDX_W-1:0]          row;
		logic [IDX_W-1:0]          col;
		logic                      first_row;
		logic                      first_col;
		logic                      last;
	} cell_t;

	// front position, for checking
	typedef struct packed {
		logic [IDX_W-1:0] row;
		logic [IDX_W-1:0] col;
	} front_pos_t;

	// queue control from the front: push request and full flag
	typedef struct packed {
		logic push;
		logic full;
	} queue_ctl_t;

	function automatic logic signed [SUM_W-1:0] sat_sum(input logic signed [PROD_W-1:0] v);
		logic signed [PROD_W-1:0] hi;
		logic signed [PROD_W-1:0] lo;
		logic signed [SUM_W-1:0]  res;
		hi = PROD_W'((64'sd1 <<< (SUM_W - 1)) - 64'sd1);
		lo = -hi - PROD_W'(1);
		if (v > hi)
			res = hi[SUM_W-1:0];
		else if (v < lo)
			res = lo[SUM_W-1:0];
		else
			res = v[SUM_W-1:0];
		return res;
	endfunction
endpackage

[sv/famcdp_front.sv]
// Front end: accepts score beats, tracks grid position, tags each cell.
`timescale 1ns / 1ps
module famcdp_front (
	input  logic                                     clk,
	input  logic                                     arst_n,
	input  logic                                     in_valid,
	output logic                                     in_stall,
	input  logic signed [famcdp_pkg::SCORE_W-1:0]   frame_score,
	input  logic [famcdp_pkg::LEN_REG_W-1:0]        first_length,
	input  logic [famcdp_pkg::LEN_REG_W-1:0]        second_length,
	input  logic                                     restart,
	output famcdp_pkg::queue_ctl_t                   qctl,
	input  logic                                     q_full,
	output famcdp_pkg::cell_t                        push_item,
	output famcdp_pkg::front_pos_t                   pos
);
	localparam int CW = famcdp_pkg::CNT_W;
	localparam int IW = famcdp_pkg::IDX_W;

	function automatic logic [CW-1:0] eff_len(input logic [famcdp_pkg::LEN_REG_W-1:0] v);
		logic [CW-1:0] res;
		if (v == '0)
			res = CW'(1);
		else if (famcdp_pkg::LEN_REG_W'(v) > famcdp_pkg::LEN_REG_W'(famcdp_pkg::MAX_FRAMES))
			res = CW'(famcdp_pkg::MAX_FRAMES);
		else
			res = CW'(v);
		return res;
	endfunction

	logic [IW-1:0] row_q, col_q;
	logic [CW-1:0] n1, n2;
	logic          accept, row_end, last;

	assign n1       = eff_len(first_length);
	assign n2       = eff_len(second_length);
	assign row_end  = (CW'(col_q) == n2 - CW'(1));
	assign last     = row_end && (CW'(row_q) == n1 - CW'(1));
	assign accept   = in_valid && !q_full;
	assign in_stall = q_full;

	assign qctl.push = accept;
	assign qctl.full = q_full;

	assign push_item.score     = frame_score;
	assign push_item.row       = row_q;
	assign push_item.col       = col_q;
	assign push_item.first_row = (row_q == '0);
	assign push_item.first_col = (col_q == '0);
	assign push_item.last      = last;

	assign pos.row = row_q;
	assign pos.col = col_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_q <= '0;
			col_q <= '0;
		end else if (restart) begin
			row_q <= '0;
			col_q <= '0;
		end else if (accept) begin
			if (last) begin
				row_q <= '0;
				col_q <= '0;
			end else if (row_end) begin
				row_q <= row_q + IW'(1);
				col_q <= '0;
			end else begin
				col_q <= col_q + IW'(1);
			end
		end
	end
endmodule

[sv/famcdp_queue.sv]
// Short cell queue between front and back.
`timescale 1ns / 1ps
module famcdp_queue (
	input  logic                   clk,
	input  logic                   arst_n,
	input  famcdp_pkg::queue_ctl_t qctl,
	input  famcdp_pkg::cell_t      push_item,
	output logic                   full,
	input  logic                   pop,
	output logic                   head_valid,
	output famcdp_pkg::cell_t      head_item
);
	localparam int PW = famcdp_pkg::QPTR_W;

	famcdp_pkg::cell_t entry_q [famcdp_pkg::QUEUE_DEPTH];
	logic [PW-1:0]     wr_ptr_q, rd_ptr_q;
	logic [PW:0]       count_q;
	logic              do_push, do_pop;

	assign full       = (count_q == (PW+1)'(famcdp_pkg::QUEUE_DEPTH));
	assign head_valid = (count_q != '0);
	assign head_item  = entry_q[rd_ptr_q];
	assign do_push    = qctl.push && !full;
	assign do_pop     = pop && head_valid;

	always_ff @(posedge clk) begin
		if (do_push)
			entry_q[wr_ptr_q] <= push_item;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push)
				wr_ptr_q <= wr_ptr_q + PW'(1);
			if (do_pop)
				rd_ptr_q <= rd_ptr_q + PW'(1);
			if (do_push && !do_pop)
				count_q <= count_q + (PW+1)'(1);
			else if (do_pop && !do_push)
				count_q <= count_q - (PW+1)'(1);
		end
	end
endmodule

[sv/famcdp_back.sv]
// Back end: cell recurrence over the row memory, then rounding divide and result register.
`timescale 1ns / 1ps
module famcdp_back (
	input  logic                                   clk,
	input  logic                                   arst_n,
	input  logic                                   head_valid,
	input  famcdp_pkg::cell_t                      head_item,
	output logic                                   pop,
	input  logic signed [famcdp_pkg::SCORE_W-1:0] deleted_score,
	input  logic signed [famcdp_pkg::SCORE_W-1:0] inserted_score,
	output logic                                   out_valid,
	input  logic                                   out_stall,
	output logic signed [famcdp_pkg::SCORE_W-1:0] quality,
	output logic [famcdp_pkg::PLEN_W-1:0]         path_length
);
	localparam int SW    = famcdp_pkg::SUM_W;
	localparam int LW    = famcdp_pkg::PLEN_W;
	localparam int CW    = famcdp_pkg::COST_W;
	localparam int PW    = famcdp_pkg::PROD_W;
	localparam int NW    = famcdp_pkg::CNT_W;
	localparam int DVD_W = SW + 1;
	localparam int DVR_W = LW + 1;
	localparam int DC_W  = $clog2(DVD_W);
	localparam int QV_W  = DVD_W + 2;
	localparam logic signed [CW-1:0]   ONE_C = CW'(famcdp_pkg::ONE_Q14);
	localparam logic signed [QV_W-1:0] ONE_Q = QV_W'(famcdp_pkg::ONE_Q14);

	typedef enum logic [4:0] {
		ST_IDLE = 5'b00001,
		ST_MUL  = 5'b00010,
		ST_CMP  = 5'b00100,
		ST_DIV  = 5'b01000,
		ST_PUT  = 5'b10000
	} back_state_t;

	back_state_t state_q;

	logic signed [SW-1:0] row_sum_mem [famcdp_pkg::MAX_FRAMES];
	logic [LW-1:0]        row_len_mem [famcdp_pkg::MAX_FRAMES];
	logic signed [SW-1:0] up_sum_rd_q;
	logic [LW-1:0]        up_len_rd_q;

	famcdp_pkg::cell_t    cell_s1;
	logic signed [PW-1:0] prod_left_s2, prod_diag_s2, prod_up_s2;

	logic signed [SW-1:0] left_sum_q, diag_sum_q;
	logic [LW-1:0]        left_len_q, diag_len_q;

	logic [DVR_W:0]       rem_q;
	logic [DVD_W-1:0]     quo_q;
	logic [DVR_W-1:0]     dvr_q;
	logic [DC_W-1:0]      dcnt_q;
	logic                 neg_q;
	logic [LW-1:0]        plen_q;

	logic                 out_valid_q;
	logic signed [famcdp_pkg::SCORE_W-1:0] quality_q;
	logic [LW-1:0]        path_length_q;

	logic signed [CW-1:0] cost_del, cost_ins, cost_diag;
	logic signed [NW:0]   rown_p1, rown, coln_p1;
	logic signed [SW-1:0] d_sum, l_sum, u_sum, cand_d, cand_u, cand_l, best;
	logic [LW-1:0]        d_len, l_len, u_len, best_len, len_nz;
	logic signed [SW:0]   best_x, mag;
	logic [DVD_W-1:0]     dividend;
	logic [DVR_W:0]       trial;
	logic signed [QV_W-1:0] qv;
	logic                 load_out;

	assign pop = (state_q == ST_IDLE) && head_valid;

	assign cost_del  = ONE_C - CW'(deleted_score);
	assign cost_ins  = ONE_C - CW'(inserted_score);
	assign cost_diag = ONE_C - CW'(cell_s1.score);

	assign rown    = (NW+1)'(cell_s1.row);
	assign rown_p1 = rown + (NW+1)'(1);
	assign coln_p1 = (NW+1)'(cell_s1.col) + (NW+1)'(1);

	// candidate selection: diagonal first, a later one wins only when strictly smaller
	always_comb begin
		d_sum  = cell_s1.first_col ? famcdp_pkg::sat_sum(prod_diag_s2) : diag_sum_q;
		d_len  = cell_s1.first_col ? LW'(cell_s1.row) : diag_len_q;
		l_sum  = cell_s1.first_col ? famcdp_pkg::sat_sum(prod_left_s2) : left_sum_q;
		l_len  = cell_s1.first_col ? LW'(rown_p1) : left_len_q;
		u_sum  = cell_s1.first_row ? famcdp_pkg::sat_sum(prod_up_s2) : up_sum_rd_q;
		u_len  = cell_s1.first_row ? LW'(coln_p1) : up_len_rd_q;
		cand_d = famcdp_pkg::sat_sum(PW'(d_sum) + PW'(cost_diag));
		cand_u = famcdp_pkg::sat_sum(PW'(u_sum) + PW'(cost_del));
		cand_l = famcdp_pkg::sat_sum(PW'(l_sum) + PW'(cost_ins));
		best     = cand_d;
		best_len = d_len + LW'(1);
		if (cand_u < best) begin
			best     = cand_u;
			best_len = u_len + LW'(1);
		end
		if (cand_l < best) begin
			best     = cand_l;
			best_len = l_len + LW'(1);
		end
	end

	// divider setup: round(|sum| / len) = (2|sum| + len) / (2 len)
	assign len_nz   = (best_len == '0) ? LW'(1) : best_len;
	assign best_x   = (SW+1)'(best);
	assign mag      = best[SW-1] ? -best_x : best_x;
	assign dividend = {mag[SW-1:0], 1'b0} + DVD_W'(len_nz);
	assign trial    = {rem_q[DVR_W-1:0], quo_q[DVD_W-1]};

	always_comb begin
		qv = neg_q ? ONE_Q + QV_W'(quo_q) : ONE_Q - QV_W'(quo_q);
		if (qv > ONE_Q)
			qv = ONE_Q;
		else if (qv < -ONE_Q)
			qv = -ONE_Q;
	end

	assign load_out = (state_q == ST_PUT) && (!out_valid_q || !out_stall);

	// row memory: one read at pop, one write at the compare step
	always_ff @(posedge clk) begin
		if (pop) begin
			up_sum_rd_q <= row_sum_mem[head_item.col];
			up_len_rd_q <= row_len_mem[head_item.col];
		end
		if (state_q == ST_CMP) begin
			row_sum_mem[cell_s1.col] <= best;
			row_len_mem[cell_s1.col] <= best_len;
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (pop)
			cell_s1 <= head_item;
		if (state_q == ST_MUL) begin
			prod_left_s2 <= rown_p1 * cost_del;
			prod_diag_s2 <= rown * cost_del;
			prod_up_s2   <= coln_p1 * cost_ins;
		end
		if (state_q == ST_CMP && cell_s1.last) begin
			rem_q  <= '0;
			quo_q  <= dividend;
			dvr_q  <= {len_nz, 1'b0};
			neg_q  <= best[SW-1];
			plen_q <= best_len;
		end else if (state_q == ST_DIV) begin
			if (trial >= (DVR_W+1)'(dvr_q)) begin
				rem_q <= trial - (DVR_W+1)'(dvr_q);
				quo_q <= {quo_q[DVD_W-2:0], 1'b1};
			end else begin
				rem_q <= trial;
				quo_q <= {quo_q[DVD_W-2:0], 1'b0};
			end
		end
		if (load_out) begin
			quality_q     <= qv[famcdp_pkg::SCORE_W-1:0];
			path_length_q <= plen_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			left_sum_q  <= '0;
			left_len_q  <= '0;
			diag_sum_q  <= '0;
			diag_len_q  <= '0;
			dcnt_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (load_out)
				out_valid_q <= 1'b1;
			else if (out_valid_q && !out_stall)
				out_valid_q <= 1'b0;
			unique case (state_q)
				ST_IDLE: begin
					if (head_valid)
						state_q <= ST_MUL;
				end
				ST_MUL: begin
					state_q <= ST_CMP;
				end
				ST_CMP: begin
					left_sum_q <= best;
					left_len_q <= best_len;
					diag_sum_q <= u_sum;
					diag_len_q <= u_len;
					if (cell_s1.last) begin
						dcnt_q  <= DC_W'(DVD_W - 1);
						state_q <= ST_DIV;
					end else begin
						state_q <= ST_IDLE;
					end
				end
				ST_DIV: begin
					dcnt_q <= dcnt_q - DC_W'(1);
					if (dcnt_q == '0)
						state_q <= ST_PUT;
				end
				ST_PUT: begin
					if (load_out)
						state_q <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	assign out_valid   = out_valid_q;
	assign quality     = quality_q;
	assign path_length = path_length_q;
endmodule

[sv/frame_alignment_min_cost_dp_top.sv]
// Sequence: a cell passes through the back-end memory read, multiply, and compare and update steps;
//   the last cell then goes through the divider and a load step before its result beat shows.
// The back-end sequencer finishes each cell before it takes the next (single-port row memory).
// The 4-entry queue lets the front take beats while the back end or the result register stalls.
// Reset (arst_n low, asynchronous): control, position and config registers return to their
//   reset values at once; the row memories are not cleared (always written before read).
`timescale 1ns / 1ps
`include "frame_alignment_min_cost_dp_top_assert.svh"
module frame_alignment_min_cost_dp_top (
	input  logic                                      clk,
	input  logic                                      arst_n,
	// score beats in
	input  logic                                      in_valid,
	output logic                                      in_stall,
	input  logic signed [famcdp_pkg::SCORE_W-1:0]    frame_score,
	// result beat out
	output logic                                      out_valid,
	input  logic                                      out_stall,
	output logic signed [famcdp_pkg::SCORE_W-1:0]    quality,
	output logic [famcdp_pkg::PLEN_W-1:0]            path_length,
	// config writes
	input  logic                                      cfg_wr_en,
	input  logic [famcdp_pkg::CFG_ADDR_W-1:0]        cfg_addr,
	input  logic [famcdp_pkg::CFG_DATA_W-1:0]        cfg_wdata
);
	localparam int LRW = famcdp_pkg::LEN_REG_W;

	logic [LRW-1:0]                           first_len_q, second_len_q;
	logic signed [famcdp_pkg::SCORE_W-1:0]   del_score_q, ins_score_q;
	logic                                     restart;

	famcdp_pkg::queue_ctl_t  qctl;
	famcdp_pkg::cell_t       push_item, head_item;
	famcdp_pkg::front_pos_t  pos;
	logic                    q_full, head_valid, pop;

	// a length write restarts the grid walk
	assign restart = cfg_wr_en &&
		(cfg_addr == famcdp_pkg::REG_FIRST_LEN || cfg_addr == famcdp_pkg::REG_SECOND_LEN);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			first_len_q  <= LRW'(1);
			second_len_q <= LRW'(1);
			del_score_q  <= '0;
			ins_score_q  <= '0;
		end else if (cfg_wr_en) begin
			unique case (famcdp_pkg::cfg_reg_t'(cfg_addr))
				famcdp_pkg::REG_FIRST_LEN:  first_len_q  <= cfg_wdata[LRW-1:0];
				famcdp_pkg::REG_SECOND_LEN: second_len_q <= cfg_wdata[LRW-1:0];
				famcdp_pkg::REG_DEL_SCORE:  del_score_q  <= cfg_wdata;
				famcdp_pkg::REG_INS_SCORE:  ins_score_q  <= cfg_wdata;
				default: ;
			endcase
		end
	end

	famcdp_front u_front (
		.clk           (clk),
		.arst_n        (arst_n),
		.in_valid      (in_valid),
		.in_stall      (in_stall),
		.frame_score   (frame_score),
		.first_length  (first_len_q),
		.second_length (second_len_q),
		.restart       (restart),
		.qctl          (qctl),
		.q_full        (q_full),
		.push_item     (push_item),
		.pos           (pos)
	);

	famcdp_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.qctl       (qctl),
		.push_item  (push_item),
		.full       (q_full),
		.pop        (pop),
		.head_valid (head_valid),
		.head_item  (head_item)
	);

	famcdp_back u_back (
		.clk            (clk),
		.arst_n         (arst_n),
		.head_valid     (head_valid),
		.head_item      (head_item),
		.pop            (pop),
		.deleted_score  (del_score_q),
		.inserted_score (ins_score_q),
		.out_valid      (out_valid),
		.out_stall      (out_stall),
		.quality        (quality),
		.path_length    (path_length)
	);

	// front never pushes into a full queue
	`FAMC_ASSERT_IMP(a_no_push_full, qctl.push, !qctl.full)
	// a length write puts the front back at the grid origin
	`FAMC_ASSERT_NEXT(a_restart_origin, restart, pos.row == '0 && pos.col == '0)
	// every result carries a nonzero path
	`FAMC_ASSERT_IMP(a_path_nonzero, out_valid, path_length != '0)
endmodule
